>>> hw/rtl/lsi_pkg.sv
// lsi_pkg: shared types and constants for the LMS system identification block.
// No dependencies.
`default_nettype none
package lsi_pkg;

  localparam int X_W   = 16;
  localparam int W_W   = 48;
  localparam int C_W   = 32;
  localparam int ACC_W = 64;
  localparam int MU_W  = 6;

  localparam logic [MU_W-1:0] MU_RESET = 6'd37;

  // register indexes of the configuration port
  localparam logic [0:0] REG_MU_SHIFT = 1'b0;

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef struct packed {
    logic shift_x;  // take x from the left neighbor (new sample enters)
    logic rot;      // take the whole tap from the right neighbor
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/lms_system_identification.sv
// lms_system_identification: top level, ring of tap cells, one MAC and the control.
// Depends on lsi_pkg, lsi_cell, lsi_wupd.
`default_nettype none
// Usage:
//  Input channel (in_valid / in_stall) carries requests. A load request
//  (req_type=1) writes reference coefficient coef_index in the accept cycle
//  and gives no result; the block stays ready. Indexes >= TAPS are ignored.
//  A sample request shifts sample_in into the delay line, then the taps
//  rotate once around the ring through a single MAC unit to form y and d,
//  then rotate again through the weight-update unit. One result
//  (filter_out, error_out) follows on the output channel.
//  out_valid rises when the result moves from S_DONE into the output
//  register; a new sample request is taken only once the block is back in
//  S_IDLE, as both ring passes go through one MAC.
//  in_stall is high while a sample is being worked on.
//  The result sits in an output register: the next request is taken while a
//  result still waits; if out_stall holds the old result when a new one is
//  done, the block waits (stall stays high) until it is taken.
//  Reset (rst_n low, synchronous) clears the delay line, weights, control
//  and sets mu_shift to 37; coefficients must be loaded before use.
//  APB port: mu_shift at byte address 0, pready always high.
module lms_system_identification #(
  parameter int TAPS = 100
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_req_type,
  input  wire  [7:0]         in_coef_index,
  input  wire  signed [31:0] in_coef_value,
  input  wire  signed [15:0] in_sample_in,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [15:0] out_filter_out,
  output logic signed [31:0] out_error_out,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(TAPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;  // first pass: rotate, form products
  localparam logic [2:0] S_FIN  = 3'd2;  // last product into sums
  localparam logic [2:0] S_ERR  = 3'd3;  // e = d - y
  localparam logic [2:0] S_SAT  = 3'd4;  // clamp e, form outputs
  localparam logic [2:0] S_MUL  = 3'd5;  // first update product
  localparam logic [2:0] S_UPD  = 3'd6;  // second pass: rotate, update weights
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  localparam logic signed [63:0] EC_MAX = 64'sh7FFFFFFFFFFF;
  localparam logic signed [63:0] Y_MAX  = 64'sd32767;
  localparam logic signed [63:0] Y_MIN  = -64'sd32768;
  localparam logic signed [63:0] E_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] E_MIN  = -64'sd2147483648;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [lsi_pkg::MU_W-1:0] mu_r;

  logic signed [15:0] x_q [TAPS];
  logic signed [47:0] w_q [TAPS];
  logic signed [31:0] c_q [TAPS];
  logic signed [47:0] w_new;
  lsi_pkg::cell_ctl_t ctl;

  logic acc_v_r;
  logic signed [63:0] py_r, pd_r, y_r, d_r, e_r, p_r;
  logic signed [47:0] ec_r;
  logic signed [15:0] yo_r, fo_r;
  logic signed [31:0] eo_r, eout_r;
  logic out_v_r;

  logic in_acc, out_acc, smp_acc, ld_acc, last;
  logic signed [63:0] mw, mc, ytr, etr, yneg, eneg;
  logic signed [15:0] xsel;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_v_r && !out_stall;
  assign smp_acc = in_acc && (in_req_type == lsi_pkg::REQ_SAMPLE);
  assign ld_acc  = in_acc && (in_req_type == lsi_pkg::REQ_LOAD)
                   && ({1'b0, in_coef_index} < 9'(TAPS));
  assign last    = (cnt_r == CW'(TAPS - 1));
  assign in_stall = (state_r != S_IDLE);

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lsi_pkg::REG_MU_SHIFT && paddr[1:0] == 2'b00)
                  ? {26'd0, mu_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r <= lsi_pkg::MU_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == lsi_pkg::REG_MU_SHIFT) begin
      mu_r <= pwdata[5:0];
    end
  end

  // ring control: rotate during both passes, shift x on a new sample
  always_comb begin
    ctl.rot     = (state_r == S_ACC) || (state_r == S_UPD);
    ctl.shift_x = smp_acc;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TAPS; gi++) begin : g_cell
      localparam int NX = (gi == TAPS - 1) ? 0 : gi + 1;
      lsi_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .load_c (ld_acc && in_coef_index == 8'(gi)),
        .c_load (in_coef_value),
        .x_left ((gi == 0) ? in_sample_in : x_q[(gi == 0) ? 0 : gi - 1]),
        .rot_x  (x_q[NX]),
        .rot_w  ((gi == TAPS - 1) ? w_new : w_q[NX]),
        .rot_c  (c_q[NX]),
        .x_o    (x_q[gi]),
        .w_o    (w_q[gi]),
        .c_o    (c_q[gi])
      );
    end
  endgenerate

  // head cell passes through the update unit on its way to the tail
  lsi_wupd u_wupd (
    .en   (state_r == S_UPD),
    .w_i  (w_q[0]),
    .p_i  (p_r),
    .mu_i (mu_r),
    .w_o  (w_new)
  );

  // MAC products from the head cell
  assign mw   = 64'(w_q[0]) * 64'(x_q[0]);
  assign mc   = 64'(c_q[0]) * 64'(x_q[0]);
  // product for the tap that is at the head in the next cycle
  assign xsel = (state_r == S_MUL) ? x_q[0] : x_q[1];

  // truncation toward zero of Q.24 values
  assign yneg = -y_r;
  assign eneg = -e_r;
  assign ytr  = y_r[63] ? -(yneg >>> 24) : (y_r >>> 24);
  assign etr  = e_r[63] ? -(eneg >>> 24) : (e_r >>> 24);

  always_ff @(posedge clk) begin
    py_r <= mw >>> 16;
    pd_r <= mc;
    if (smp_acc) begin
      y_r <= '0;
      d_r <= '0;
    end else if (acc_v_r) begin
      y_r <= y_r + py_r;
      d_r <= d_r + pd_r;
    end
    if (state_r == S_ERR) e_r <= d_r - y_r;
    if (state_r == S_SAT) begin
      if (e_r > EC_MAX) ec_r <= EC_MAX[47:0];
      else if (e_r < -EC_MAX) ec_r <= -EC_MAX[47:0];
      else ec_r <= e_r[47:0];
      if (ytr > Y_MAX) yo_r <= Y_MAX[15:0];
      else if (ytr < Y_MIN) yo_r <= Y_MIN[15:0];
      else yo_r <= ytr[15:0];
      if (etr > E_MAX) eo_r <= E_MAX[31:0];
      else if (etr < E_MIN) eo_r <= E_MIN[31:0];
      else eo_r <= etr[31:0];
    end
    p_r <= 64'(ec_r) * 64'(xsel);
    if (state_r == S_DONE && (!out_v_r || out_acc)) begin
      fo_r   <= yo_r;
      eout_r <= eo_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (smp_acc) state_nxt = S_ACC;
      end
      S_ACC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN:  state_nxt = S_ERR;
      S_ERR:  state_nxt = S_SAT;
      S_SAT:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_UPD;
      S_UPD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_acc) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      acc_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_v_r <= (state_r == S_ACC);
      if (state_r == S_DONE && (!out_v_r || out_acc)) out_v_r <= 1'b1;
      else if (out_acc) out_v_r <= 1'b0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_filter_out = fo_r;
  assign out_error_out  = eout_r;

endmodule
`default_nettype wire

>>> hw/rtl/lsi_cell.sv
// lsi_cell: one tap of the ring: sample, adaptive weight and reference coefficient.
// Depends on lsi_pkg.
`default_nettype none
module lsi_cell (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  lsi_pkg::cell_ctl_t            ctl,
  input  wire                                 load_c,
  input  wire  logic signed [lsi_pkg::C_W-1:0] c_load,
  input  wire  logic signed [lsi_pkg::X_W-1:0] x_left,
  input  wire  logic signed [lsi_pkg::X_W-1:0] rot_x,
  input  wire  logic signed [lsi_pkg::W_W-1:0] rot_w,
  input  wire  logic signed [lsi_pkg::C_W-1:0] rot_c,
  output logic signed [lsi_pkg::X_W-1:0]      x_o,
  output logic signed [lsi_pkg::W_W-1:0]      w_o,
  output logic signed [lsi_pkg::C_W-1:0]      c_o
);

  logic signed [lsi_pkg::X_W-1:0] x_r;
  logic signed [lsi_pkg::W_W-1:0] w_r;
  logic signed [lsi_pkg::C_W-1:0] c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= '0;
    end else if (ctl.rot) begin
      x_r <= rot_x;
      w_r <= rot_w;
    end else if (ctl.shift_x) begin
      x_r <= x_left;
    end
  end

  // coefficients have no reset; read only after being loaded
  always_ff @(posedge clk) begin
    if (ctl.rot) begin
      c_r <= rot_c;
    end else if (load_c) begin
      c_r <= c_load;
    end
  end

  assign x_o = x_r;
  assign w_o = w_r;
  assign c_o = c_r;

endmodule
`default_nettype wire

>>> hw/rtl/lsi_wupd.sv
// lsi_wupd: weight step: scales the registered product by 2^(16-mu) with limits
// and adds it to the weight with saturation. Depends on lsi_pkg.
`default_nettype none
module lsi_wupd (
  input  wire                                   en,
  input  wire  logic signed [lsi_pkg::W_W-1:0]   w_i,
  input  wire  logic signed [lsi_pkg::ACC_W-1:0] p_i,
  input  wire  logic [lsi_pkg::MU_W-1:0]         mu_i,
  output logic signed [lsi_pkg::W_W-1:0]        w_o
);

  localparam logic signed [63:0] DLIM = 64'sd1 <<< 48;
  localparam logic signed [50:0] WMAX = 51'sh7FFFFFFFFFFF;
  localparam logic signed [50:0] WMIN = -51'sh800000000000;

  logic [lsi_pkg::MU_W-1:0] k;
  logic [lsi_pkg::MU_W-1:0] rs;
  logic signed [63:0] sh;
  logic signed [63:0] lim;
  logic signed [63:0] dl;
  logic signed [50:0] sum;

  always_comb begin
    k   = 6'd16 - mu_i;
    rs  = mu_i - 6'd16;
    sh  = p_i >>> rs;
    lim = DLIM >>> k;
    if (mu_i >= 6'd16) begin
      if (sh > DLIM) dl = DLIM;
      else if (sh < -DLIM) dl = -DLIM;
      else dl = sh;
    end else begin
      if (p_i > lim) dl = DLIM;
      else if (p_i < -lim) dl = -DLIM;
      else dl = p_i <<< k;
    end
    sum = {{3{w_i[47]}}, w_i} + {dl[49], dl[49:0]};
    if (!en) w_o = w_i;
    else if (sum > WMAX) w_o = WMAX[47:0];
    else if (sum < WMIN) w_o = WMIN[47:0];
    else w_o = sum[47:0];
  end

endmodule
`default_nettype wire

>>> hw/rtl/lsi_checker.sv
// lsi_checker: port-level assertions for lms_system_identification, plus bind.
// Depends on the top level's ports only.
`default_nettype none
module lsi_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire               in_req_type,
  input wire               out_valid,
  input wire               out_stall,
  input wire signed [15:0] out_filter_out,
  input wire signed [31:0] out_error_out
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filter_out)
      && $stable(out_error_out))
    else $error("result changed while stalled");

  // a sample request occupies the block in the next cycle
  a_smp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_req_type |=> in_stall)
    else $error("no stall after sample request");

  // a load request never occupies the block
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req_type |=> !in_stall)
    else $error("stall after load request");

  // a new result appears only at the end of sample work
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without sample work");

endmodule

bind lms_system_identification lsi_checker u_lsi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_filter_out (out_filter_out),
  .out_error_out  (out_error_out)
);
`default_nettype wire

>>> sim/tb_lms_system_identification.sv
// tb_lms_system_identification: self-checking bench for the LMS system identification block.
// Depends on lsi_pkg and lms_system_identification; the predictor below mirrors
// the fixed-point LMS update and checks every result in order.
`default_nettype none
module tb_lms_system_identification;

  localparam int TAPS = 100;
  localparam longint W_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint W_MIN = -W_MAX - 1;
  localparam longint DLIM = 64'sh1_0000_0000_0000;  // 2^48

  typedef struct {
    logic         kind;
    logic [7:0]   idx;
    int           coef;
    shortint      smp;
  } request_t;

  typedef struct {
    shortint filt;
    int      err;
  } lms_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = lsi_pkg::REQ_SAMPLE;
  logic [7:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [15:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_filter_out;
  logic signed [31:0] out_error_out;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lms_system_identification #(.TAPS(TAPS)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  shortint     taps_x[TAPS];
  longint      weights[TAPS];
  int          ref_coef[TAPS];
  logic [5:0]  mu;

  request_t    req_queue[$];
  lms_result_t pending_results[$];
  request_t    cur;
  int          mismatches = 0;
  int          tx_idle = 17, rx_idle = 51;
  logic        tx_pause = 1'b0, rx_hold = 1'b0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // integer part of a Q.24 value, rounded toward zero
  function automatic longint int_part(longint v);
    return v < 0 ? -((-v) >>> 24) : v >>> 24;
  endfunction

  // apply one request to the predicted filter; samples yield one result
  function automatic void lms_update(request_t r);
    longint y, d, e, ec, p, delta, lim;
    int k;
    lms_result_t res;
    y = 0;
    d = 0;
    if (r.kind == lsi_pkg::REQ_LOAD) begin
      if (r.idx < TAPS) ref_coef[r.idx] = r.coef;
      return;
    end
    for (int n = TAPS - 1; n > 0; n--) taps_x[n] = taps_x[n-1];
    taps_x[0] = r.smp;
    for (int n = 0; n < TAPS; n++) begin
      y += (weights[n] * longint'(taps_x[n])) >>> 16;
      d += longint'(ref_coef[n]) * longint'(taps_x[n]);
    end
    e = d - y;
    ec = clampl(e, -W_MAX, W_MAX);
    for (int n = 0; n < TAPS; n++) begin
      p = ec * longint'(taps_x[n]);
      if (mu >= 16) begin
        delta = p >>> (mu - 16);
      end else begin
        k = 16 - mu;
        lim = DLIM >>> k;
        if (p > lim) delta = DLIM;
        else if (p < -lim) delta = -DLIM;
        else delta = p <<< k;
      end
      delta = clampl(delta, -DLIM, DLIM);
      weights[n] = clampl(weights[n] + delta, W_MIN, W_MAX);
    end
    res.filt = shortint'(clampl(int_part(y), -32768, 32767));
    res.err = int'(clampl(int_part(e), -64'sd2147483648, 64'sd2147483647));
    pending_results.push_back(res);
  endfunction

  // driver: prediction at accept, then next request or a gap
  always @(posedge clk) begin
    logic took;
    took = in_valid && !in_stall;
    if (took) lms_update(cur);
    if (!in_valid || took) begin
      if (rst_n && !tx_pause && req_queue.size() > 0 && $urandom_range(99) >= tx_idle) begin
        cur = req_queue.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur.kind;
        in_coef_index <= cur.idx;
        in_coef_value <= cur.coef;
        in_sample_in <= cur.smp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and result checking
  always @(posedge clk) begin
    lms_result_t x;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result y=%0d e=%0d",
                                       out_filter_out, out_error_out);
      end else begin
        x = pending_results.pop_front();
        if (out_filter_out !== x.filt || out_error_out !== x.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: y exp %0d got %0d, e exp %0d got %0d",
                     x.filt, out_filter_out, x.err, out_error_out);
        end
      end
    end
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle);
  end

  function automatic request_t mk_load(int idx, int val);
    request_t r;
    r.kind = lsi_pkg::REQ_LOAD;
    r.idx = idx[7:0];
    r.coef = val;
    r.smp = shortint'($urandom);
    return r;
  endfunction

  function automatic request_t mk_sample(int s);
    request_t r;
    r.kind = lsi_pkg::REQ_SAMPLE;
    r.idx = 8'($urandom);
    r.coef = $urandom;
    r.smp = s[15:0];
    return r;
  endfunction

  // random request: mostly samples, some coefficient reloads incl. ignored indexes
  function automatic request_t rand_request();
    int s, v;
    case ($urandom_range(9))
      0: s = 32767;
      1: s = -32768;
      2, 3: s = $signed($urandom_range(511)) - 256;
      default: s = $signed(16'($urandom));
    endcase
    if ($urandom_range(99) < 18) begin
      v = $urandom_range(1) ? $urandom : ($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      return mk_load($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(TAPS - 1), v);
    end
    return mk_sample(s);
  endfunction

  // wait until nothing is in flight, plus the block's latency
  task automatic settle();
    while (req_queue.size() > 0 || in_valid || pending_results.size() > 0) @(posedge clk);
    repeat (2 * TAPS + 50) @(posedge clk);
  endtask

  task automatic mu_write(logic [5:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {lsi_pkg::REG_MU_SHIFT, 2'b00};
    pwdata <= {26'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mu = v;
  endtask

  task automatic run_phase(logic [5:0] m, int n);
    settle();
    mu_write(m);
    repeat (n) req_queue.push_back(rand_request());
  endtask

  initial begin
    foreach (taps_x[i]) taps_x[i] = 0;
    foreach (weights[i]) weights[i] = 0;
    foreach (ref_coef[i]) ref_coef[i] = 0;
    mu = lsi_pkg::MU_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every coefficient is loaded before the first sample reads it
    for (int i = 0; i < TAPS; i++)
      req_queue.push_back(mk_load(i, $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000));
    // directed: extreme coefficients, ignored indexes, extreme samples
    req_queue.push_back(mk_load(0, 32'sh7FFF_FFFF));
    req_queue.push_back(mk_load(TAPS - 1, 32'sh8000_0000));
    req_queue.push_back(mk_load(TAPS, 32'sh1234_5678));
    req_queue.push_back(mk_load(255, -1));
    req_queue.push_back(mk_sample(32767));
    req_queue.push_back(mk_sample(-32768));
    req_queue.push_back(mk_sample(0));
    req_queue.push_back(mk_sample(-1));
    req_queue.push_back(mk_sample(1));
    req_queue.push_back(mk_load(1, 0));
    req_queue.push_back(mk_sample(-32768));
    req_queue.push_back(mk_sample(32767));

    // sender 17%, receiver 51% idle; long receiver hold to back up the pipe
    run_phase(6'd37, 49);
    rx_hold <= 1'b1;
    repeat (3 * TAPS * 4) @(posedge clk);
    rx_hold <= 1'b0;
    run_phase(6'd63, 49);
    run_phase(6'd0, 46);
    // sender pauses mid-phase until all results are back
    tx_idle = 51;
    rx_idle = 17;
    run_phase(6'd20, 49);
    repeat (600) @(posedge clk);
    tx_pause <= 1'b1;
    while (pending_results.size() > 0 || in_valid) @(posedge clk);
    tx_pause <= 1'b0;
    run_phase(6'd15, 49);
    run_phase(6'd30, 49);
    tx_idle = 0;
    rx_idle = 0;
    run_phase(6'd40, 49);
    run_phase(6'd25, 49);
    run_phase(6'd37, 49);

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> lms_system_identification.f
hw/rtl/lsi_pkg.sv
hw/rtl/lsi_cell.sv
hw/rtl/lsi_wupd.sv
hw/rtl/lms_system_identification.sv
hw/rtl/lsi_checker.sv
sim/tb_lms_system_identification.sv
